>>> rtl/core/bc_pkg.sv
// ----------------------------------------------------------------------------
// Binomial coefficient package
// Shared payload types, widths and the command/status structs that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package bc_pkg;

    // Field widths
    localparam int N_W      = 6;
    localparam int COEF_W   = 60;
    localparam int PROD_W   = COEF_W + N_W;    // running value times a 6-bit factor
    localparam int REM_W    = N_W;             // divisor never exceeds 32
    localparam int DIV_CYC  = PROD_W / 2;      // two quotient bits per cycle
    localparam int CNT_W    = $clog2(DIV_CYC);

    // Largest set size handled; larger n saturates to this
    localparam logic [N_W-1:0] MAX_N = 6'd63;

    // Input beat
    typedef struct packed {
        logic [N_W-1:0] n_total;
        logic [N_W-1:0] k_chosen;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [COEF_W-1:0] coefficient;
        logic              invalid;
    } out_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture a new item and set up the step loop
        logic mul;       // form value * (n+1-i) and start the division
        logic div;       // one radix-4 division iteration
        logic out_load;  // move the finished result into the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic steps_done;  // step index has passed min(k, n-k)
        logic div_last;    // the current iteration is the final one
    } stat_t;

endpackage

>>> rtl/core/bc_datapath.sv
// ----------------------------------------------------------------------------
// Binomial coefficient datapath
// Holds the running value, the step index and a radix-4 restoring divider
// that divides value * (n+1-i) exactly by i, plus the output register.
// ----------------------------------------------------------------------------
module bc_datapath (
    input  logic          aclk,
    input  logic          aresetn,
    input  bc_pkg::in_t   in_data,
    input  bc_pkg::cmd_t  cmd,
    output bc_pkg::stat_t stat,
    output bc_pkg::out_t  out_data
);

    logic [bc_pkg::N_W-1:0]    n_reg, n_next;
    logic [bc_pkg::N_W-1:0]    steps_reg, steps_next;
    logic [bc_pkg::N_W-1:0]    i_reg, i_next;
    logic                      invalid_reg, invalid_next;
    logic [bc_pkg::COEF_W-1:0] val_reg, val_next;
    logic [bc_pkg::PROD_W-1:0] div_reg, div_next;
    logic [bc_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [bc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    bc_pkg::out_t              out_reg, out_next;

    logic [bc_pkg::N_W-1:0]    n_sat;
    logic [bc_pkg::N_W-1:0]    n_minus_k;
    logic [bc_pkg::N_W:0]      factor_wide;
    logic [bc_pkg::N_W-1:0]    factor;
    logic [bc_pkg::PROD_W-1:0] product;
    logic [bc_pkg::REM_W:0]    trial1, trial2;
    logic [bc_pkg::REM_W-1:0]  rem1, rem2;
    logic                      qbit1, qbit2;

    // Input conditioning: saturate n, then work out the step count
    always_comb begin
        n_sat     = (in_data.n_total > bc_pkg::MAX_N) ? bc_pkg::MAX_N : in_data.n_total;
        n_minus_k = n_sat - in_data.k_chosen;
    end

    // Multiplier: running value times (n + 1 - i)
    always_comb begin
        factor_wide = {1'b0, n_reg} + 7'd1 - {1'b0, i_reg};
        factor      = factor_wide[bc_pkg::N_W-1:0];
        product     = bc_pkg::PROD_W'(val_reg) * bc_pkg::PROD_W'(factor);
    end

    // Two restoring division steps per cycle, dividend shifted out at the top
    always_comb begin
        trial1 = {rem_reg, div_reg[bc_pkg::PROD_W-1]};
        qbit1  = (trial1 >= {1'b0, i_reg});
        rem1   = qbit1 ? bc_pkg::REM_W'(trial1 - {1'b0, i_reg})
                       : trial1[bc_pkg::REM_W-1:0];
        trial2 = {rem1, div_reg[bc_pkg::PROD_W-2]};
        qbit2  = (trial2 >= {1'b0, i_reg});
        rem2   = qbit2 ? bc_pkg::REM_W'(trial2 - {1'b0, i_reg})
                       : trial2[bc_pkg::REM_W-1:0];
    end

    // Next-state logic for the datapath registers
    always_comb begin
        n_next       = n_reg;
        steps_next   = steps_reg;
        i_next       = i_reg;
        invalid_next = invalid_reg;
        val_next     = val_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        out_next     = out_reg;

        if (cmd.load) begin
            n_next       = n_sat;
            invalid_next = (in_data.k_chosen > n_sat);
            if (in_data.k_chosen > n_sat) begin
                steps_next = '0;
            end else if (in_data.k_chosen < n_minus_k) begin
                steps_next = in_data.k_chosen;
            end else begin
                steps_next = n_minus_k;
            end
            i_next   = bc_pkg::N_W'(1);
            val_next = bc_pkg::COEF_W'(1);
        end

        if (cmd.mul) begin
            div_next = product;
            rem_next = '0;
            cnt_next = '0;
        end

        if (cmd.div) begin
            div_next = {div_reg[bc_pkg::PROD_W-3:0], qbit1, qbit2};
            rem_next = rem2;
            cnt_next = cnt_reg + 1'b1;
            // On the final iteration the quotient is the new running value
            if (stat.div_last) begin
                val_next = {div_reg[bc_pkg::COEF_W-3:0], qbit1, qbit2};
                i_next   = i_reg + 1'b1;
            end
        end

        if (cmd.out_load) begin
            out_next.coefficient = invalid_reg ? '0 : val_reg;
            out_next.invalid     = invalid_reg;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        steps_reg   <= steps_next;
        i_reg       <= i_next;
        invalid_reg <= invalid_next;
        val_reg     <= val_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        out_reg     <= out_next;
    end

    // Status back to the controller
    assign stat.steps_done = (i_reg > steps_reg);
    assign stat.div_last   = (cnt_reg == bc_pkg::CNT_W'(bc_pkg::DIV_CYC - 1));
    assign out_data        = out_reg;

    // The divisor is never zero while dividing
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div |-> (i_reg != '0))
        else $error("division started with a zero divisor");

    // A multiply is only issued while steps remain
    a_mul_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |-> (i_reg <= steps_reg))
        else $error("multiply issued past the last step");

    // Every step divides exactly
    a_exact_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div && stat.div_last) |=> (rem_reg == '0))
        else $error("step division left a non-zero remainder");

endmodule

>>> rtl/core/bc_ctrl.sv
// ----------------------------------------------------------------------------
// Binomial coefficient controller
// Sequences load, multiply and divide commands over the step loop and owns
// the handshake flags of both channels.
// ----------------------------------------------------------------------------
module bc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  bc_pkg::stat_t stat,
    output bc_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Next-state and command decode
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = stat.steps_done ? ST_FIN : ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_CHECK;
                end
            end
            ST_FIN: begin
                // Hand over once the output register is free or being emptied
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // A division runs to its final iteration without leaving the state
    a_div_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && !stat.div_last) |=> (state_reg == ST_DIV))
        else $error("division left early");

    // A result beat stays offered until it is taken
    a_m_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result beat withdrawn before acceptance");

    // At most one command is issued in any cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

endmodule

>>> rtl/core/binomial_coefficient_top.sv
// ----------------------------------------------------------------------------
// Binomial coefficient top level
// Returns C(n,k) by the multiplicative rule with an exact division per step.
//
//   Channel  Ports                     Beat
//   input    s_valid s_ready s_data    n_total, k_chosen
//   result   m_valid m_ready m_data    coefficient, invalid
//
// An item passes through the accepting state, a check, min(k, n-k) steps and
// the state that loads the result register. Each step is one multiply state,
// the radix-4 divider over the 66-bit product, and one check state.
// One item is in flight at a time; a new one is accepted while the previous
// result waits in the output register. A finished item whose result cannot
// move on waits in the last state and holds off the input until then.
// Reset is synchronous and active low; it empties the output register.
// ----------------------------------------------------------------------------
module binomial_coefficient_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  bc_pkg::in_t  s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output bc_pkg::out_t m_data
);

    bc_pkg::cmd_t  cmd;
    bc_pkg::stat_t stat;

    // Sequencer
    bc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic and result register
    bc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_data)
    );

endmodule
